// ===== hdl/eihc_pkg.sv =====
// Package for the Ethernet/IPv4 header classifier.
// Holds phase encoding, status and direction codes, register indexes and the result struct.
// No dependencies.
package eihc_pkg;

  localparam int NUM_RANGES_DEF      = 3;
  localparam int MPLS_SKIP_BYTES_DEF = 4;
  localparam int PPPOE_SKIP_BYTES    = 8;
  localparam int MAC_BYTES           = 12;
  localparam int IP_HDR_BYTES        = 20;
  localparam int QUEUE_DEPTH         = 2;

  typedef enum logic [2:0] {
    PH_MAC  = 3'd0,
    PH_TYPE = 3'd1,
    PH_VLAN = 3'd2,
    PH_SKIP = 3'd3,
    PH_IP   = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  localparam logic [2:0] ST_UNKNOWN   = 3'd0;
  localparam logic [2:0] ST_NOT_V4    = 3'd1;
  localparam logic [2:0] ST_NOT_L4    = 3'd2;
  localparam logic [2:0] ST_NO_DIR    = 3'd3;
  localparam logic [2:0] ST_ACCEPTED  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_UP       = 2'd1;
  localparam logic [1:0] DIR_DOWN     = 2'd2;
  localparam logic [1:0] DIR_UNMAPPED = 2'd3;

  localparam logic [2:0] REG_RANGE_COUNT    = 3'd0;
  localparam logic [2:0] REG_RANGE0_NETWORK = 3'd1;
  localparam logic [2:0] REG_RANGE0_MASK    = 3'd2;
  localparam logic [2:0] REG_RANGE1_NETWORK = 3'd3;
  localparam logic [2:0] REG_RANGE1_MASK    = 3'd4;
  localparam logic [2:0] REG_RANGE2_NETWORK = 3'd5;
  localparam logic [2:0] REG_RANGE2_MASK    = 3'd6;
  localparam logic [2:0] REG_KEEP_UNMAPPED  = 3'd7;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_MPLS  = 16'h8847;
  localparam logic [15:0] ETH_PPPOE = 16'h8864;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [5:0]  header_length;
    logic [15:0] identification;
    logic [7:0]  time_to_live;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [1:0]  direction;
  } result_t;

endpackage

// ===== hdl/eihc_parser.sv =====
// Front part: byte-wise header parser and range classifier.
// Depends on eihc_pkg. Emits one result_t per frame on the frame_end byte.
module eihc_parser #(
  parameter int NUM_RANGES      = eihc_pkg::NUM_RANGES_DEF,
  parameter int MPLS_SKIP_BYTES = eihc_pkg::MPLS_SKIP_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            data_byte,
  input  logic                  frame_end,
  input  logic [1:0]            range_count,
  input  logic [NUM_RANGES*32-1:0] range_network,
  input  logic [NUM_RANGES*32-1:0] range_mask,
  input  logic                  keep_unmapped,
  output logic                  res_valid,
  output eihc_pkg::result_t     res
);

  eihc_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [47:0] dmac_r, dmac_nxt, smac_r, smac_nxt;
  logic [7:0]  type_hi_r, type_hi_nxt;
  logic [3:0]  ver_r, ver_nxt, ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt, ttl_r, ttl_nxt;
  logic [15:0] tlen_r, tlen_nxt, ident_r, ident_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [1:0]  dir_r, dir_nxt;

  logic [15:0] type_word;
  logic [63:0] addr_shift;
  logic [1:0]  dir_found;

  assign addr_shift = {addr_r[55:0], data_byte};

  // Range compare on the address word as completed by this byte; first hit wins.
  always_comb begin
    logic [31:0] s, d, lo, hi, m;
    logic hit;
    s = addr_shift[63:32];
    d = addr_shift[31:0];
    dir_found = eihc_pkg::DIR_NONE;
    hit = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      m  = range_mask[i*32 +: 32];
      lo = range_network[i*32 +: 32] & m;
      hi = lo | ~m;
      if (!hit && (32'(i) < 32'(range_count))) begin
        if (s > lo && s < hi) begin
          if (d != hi) begin
            dir_found = eihc_pkg::DIR_UP;
            hit = 1'b1;
          end
        end else if (d > lo && d < hi) begin
          if (s != hi) begin
            dir_found = eihc_pkg::DIR_DOWN;
            hit = 1'b1;
          end
        end
      end
    end
    if (!hit && keep_unmapped) dir_found = eihc_pkg::DIR_UNMAPPED;
  end

  assign type_word = {type_hi_r, data_byte};

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    dmac_nxt    = dmac_r;
    smac_nxt    = smac_r;
    type_hi_nxt = type_hi_r;
    ver_nxt = ver_r; ihl_nxt = ihl_r; proto_nxt = proto_r; ttl_nxt = ttl_r;
    tlen_nxt = tlen_r; ident_nxt = ident_r; addr_nxt = addr_r;
    verdict_nxt = verdict_r; dir_nxt = dir_r;
    if (byte_en) begin
      unique case (phase_r)
        eihc_pkg::PH_MAC: begin
          if (cnt_r < 6'd6) dmac_nxt = {dmac_r[39:0], data_byte};
          else              smac_nxt = {smac_r[39:0], data_byte};
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'(eihc_pkg::MAC_BYTES - 1)) begin
            phase_nxt = eihc_pkg::PH_TYPE;
            cnt_nxt   = '0;
          end
        end
        eihc_pkg::PH_TYPE, eihc_pkg::PH_VLAN: begin
          if ((phase_r == eihc_pkg::PH_TYPE && cnt_r == 6'd0) ||
              (phase_r == eihc_pkg::PH_VLAN && cnt_r == 6'd2)) begin
            type_hi_nxt = data_byte;
            cnt_nxt = cnt_r + 6'd1;
          end else if ((phase_r == eihc_pkg::PH_TYPE) ||
                       (phase_r == eihc_pkg::PH_VLAN && cnt_r == 6'd3)) begin
            cnt_nxt = '0;
            priority if (type_word == eihc_pkg::ETH_IPV4) phase_nxt = eihc_pkg::PH_IP;
            else if (type_word == eihc_pkg::ETH_VLAN) phase_nxt = eihc_pkg::PH_VLAN;
            else if (type_word == eihc_pkg::ETH_MPLS) begin
              phase_nxt = eihc_pkg::PH_SKIP;
              cnt_nxt = 6'(MPLS_SKIP_BYTES);
            end else if (type_word == eihc_pkg::ETH_PPPOE) begin
              phase_nxt = eihc_pkg::PH_SKIP;
              cnt_nxt = 6'(eihc_pkg::PPPOE_SKIP_BYTES);
            end else begin
              phase_nxt = eihc_pkg::PH_DONE;
              verdict_nxt = eihc_pkg::ST_UNKNOWN;
            end
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
        eihc_pkg::PH_SKIP: begin
          if (cnt_r <= 6'd1) begin
            cnt_nxt = '0;
            phase_nxt = eihc_pkg::PH_IP;
          end else begin
            cnt_nxt = cnt_r - 6'd1;
          end
        end
        eihc_pkg::PH_IP: begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd0) begin
            ver_nxt = data_byte[7:4];
            ihl_nxt = data_byte[3:0];
            if (data_byte[7:4] != 4'd4) begin
              phase_nxt = eihc_pkg::PH_DONE;
              verdict_nxt = eihc_pkg::ST_NOT_V4;
            end
          end else if (cnt_r == 6'd2) tlen_nxt[15:8] = data_byte;
          else if (cnt_r == 6'd3) tlen_nxt[7:0] = data_byte;
          else if (cnt_r == 6'd4) ident_nxt[15:8] = data_byte;
          else if (cnt_r == 6'd5) ident_nxt[7:0] = data_byte;
          else if (cnt_r == 6'd8) ttl_nxt = data_byte;
          else if (cnt_r == 6'd9) begin
            proto_nxt = data_byte;
            if (data_byte != eihc_pkg::PROTO_TCP && data_byte != eihc_pkg::PROTO_UDP) begin
              phase_nxt = eihc_pkg::PH_DONE;
              verdict_nxt = eihc_pkg::ST_NOT_L4;
            end
          end else if (cnt_r >= 6'd12) begin
            addr_nxt = addr_shift;
            if (cnt_r == 6'(eihc_pkg::IP_HDR_BYTES - 1)) begin
              dir_nxt = dir_found;
              verdict_nxt = (dir_found == eihc_pkg::DIR_NONE) ?
                            eihc_pkg::ST_NO_DIR : eihc_pkg::ST_ACCEPTED;
              phase_nxt = eihc_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result built from the values this byte leaves behind.
  always_comb begin
    logic [2:0] st;
    st = (phase_nxt == eihc_pkg::PH_DONE) ? verdict_nxt : eihc_pkg::ST_TRUNCATED;
    res = '0;
    res.status   = st;
    res.dest_mac = dmac_nxt;
    res.src_mac  = smac_nxt;
    if (st >= eihc_pkg::ST_NOT_V4 && st <= eihc_pkg::ST_ACCEPTED) res.ip_version = ver_nxt;
    if (st == eihc_pkg::ST_NO_DIR || st == eihc_pkg::ST_ACCEPTED) begin
      res.protocol       = proto_nxt;
      res.total_length   = tlen_nxt;
      res.header_length  = {ihl_nxt, 2'b00};
      res.identification = ident_nxt;
      res.time_to_live   = ttl_nxt;
      res.source_ip      = addr_nxt[63:32];
      res.dest_ip        = addr_nxt[31:0];
      res.direction      = dir_nxt;
    end
  end

  assign res_valid = byte_en & frame_end;

  // Clear the frame state once the frame_end byte is taken.
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && frame_end)) begin
      phase_r <= eihc_pkg::PH_MAC;
      cnt_r <= '0; dmac_r <= '0; smac_r <= '0; type_hi_r <= '0;
      ver_r <= '0; ihl_r <= '0; proto_r <= '0; ttl_r <= '0;
      tlen_r <= '0; ident_r <= '0; addr_r <= '0; verdict_r <= '0; dir_r <= '0;
    end else begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; dmac_r <= dmac_nxt; smac_r <= smac_nxt;
      type_hi_r <= type_hi_nxt; ver_r <= ver_nxt; ihl_r <= ihl_nxt;
      proto_r <= proto_nxt; ttl_r <= ttl_nxt; tlen_r <= tlen_nxt;
      ident_r <= ident_nxt; addr_r <= addr_nxt; verdict_r <= verdict_nxt;
      dir_r <= dir_nxt;
    end
  end

endmodule

// ===== hdl/eihc_queue.sv =====
// Back part: short result queue between parser and output channel.
// Depends on eihc_pkg. Drives the output handshake and the input stall.
module eihc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  eihc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output eihc_pkg::result_t out_data
);

  localparam int D = eihc_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  eihc_pkg::result_t mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic pop;

  assign out_valid = (cnt_r != '0);
  assign full      = (cnt_r == (AW+1)'(D));
  assign pop       = out_valid & ~out_stall;
  assign out_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(D-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(D-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hdl/ethernet_ipv4_header_classifier.sv =====
// Ethernet/IPv4 header classifier: one byte per cycle, one result per frame.
// The result of a frame enters the output queue at the frame_end byte and is
// offered from the queue. Throughput: one byte each cycle; the input stalls
// only when the two-entry result queue is full and the next byte would end a frame.
// Reset (rst_n low, synchronous): parser back to the MAC phase, queue empty,
// all configuration registers zero.
module ethernet_ipv4_header_classifier #(
  parameter int NUM_RANGES      = eihc_pkg::NUM_RANGES_DEF,
  parameter int MPLS_SKIP_BYTES = eihc_pkg::MPLS_SKIP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_src_mac,
  output logic [3:0]  out_ip_version,
  output logic [7:0]  out_protocol,
  output logic [15:0] out_total_length,
  output logic [5:0]  out_header_length,
  output logic [15:0] out_identification,
  output logic [7:0]  out_time_to_live,
  output logic [31:0] out_source_ip,
  output logic [31:0] out_dest_ip,
  output logic [1:0]  out_direction,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [1:0]  range_count_r;
  logic [NUM_RANGES*32-1:0] net_r, mask_r;
  logic        keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r <= '0; net_r <= '0; mask_r <= '0; keep_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == eihc_pkg::REG_RANGE_COUNT) range_count_r <= cfg_data[1:0];
      else if (cfg_index == eihc_pkg::REG_KEEP_UNMAPPED) keep_r <= cfg_data[0];
      else begin
        for (int i = 0; i < NUM_RANGES; i++) begin
          if (cfg_index == 3'(int'(eihc_pkg::REG_RANGE0_NETWORK) + 2*i))
            net_r[i*32 +: 32] <= cfg_data;
          if (cfg_index == 3'(int'(eihc_pkg::REG_RANGE0_MASK) + 2*i))
            mask_r[i*32 +: 32] <= cfg_data;
        end
      end
    end
  end

  // Ranges beyond NUM_RANGES are never used.
  logic [1:0] eff_count;
  assign eff_count = (32'(range_count_r) > NUM_RANGES) ? 2'(NUM_RANGES) : range_count_r;

  logic accept, res_valid, q_full;
  eihc_pkg::result_t res, q_out;

  // Hold only the frame-ending byte while the queue is full.
  assign in_stall = q_full & in_frame_end;
  assign accept   = in_valid & ~in_stall;

  eihc_parser #(.NUM_RANGES(NUM_RANGES), .MPLS_SKIP_BYTES(MPLS_SKIP_BYTES)) u_parser (
    .clk, .rst_n, .byte_en(accept), .data_byte(in_data_byte), .frame_end(in_frame_end),
    .range_count(eff_count), .range_network(net_r), .range_mask(mask_r),
    .keep_unmapped(keep_r), .res_valid, .res
  );

  eihc_queue u_queue (
    .clk, .rst_n, .push(res_valid), .push_data(res), .full(q_full),
    .out_valid, .out_stall, .out_data(q_out)
  );

  assign out_status         = q_out.status;
  assign out_dest_mac       = q_out.dest_mac;
  assign out_src_mac        = q_out.src_mac;
  assign out_ip_version     = q_out.ip_version;
  assign out_protocol       = q_out.protocol;
  assign out_total_length   = q_out.total_length;
  assign out_header_length  = q_out.header_length;
  assign out_identification = q_out.identification;
  assign out_time_to_live   = q_out.time_to_live;
  assign out_source_ip      = q_out.source_ip;
  assign out_dest_ip        = q_out.dest_ip;
  assign out_direction      = q_out.direction;

endmodule

// ===== hdl/eihc_checker.sv =====
// Port-level checker for the classifier, bound to the top level.
// Depends on eihc_pkg and the ethernet_ipv4_header_classifier ports.
module eihc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_frame_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [1:0] out_direction,
  input logic [5:0] out_header_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= eihc_pkg::ST_TRUNCATED)
    else $error("bad status");

  a_dir_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != eihc_pkg::ST_ACCEPTED |-> out_direction == eihc_pkg::DIR_NONE)
    else $error("direction without accept");

  a_stall_eof: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_frame_end)
    else $error("stall on a mid-frame byte");

  a_hlen_mult4: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_header_length[1:0] == 2'b00)
    else $error("header length not a multiple of four");

endmodule

bind ethernet_ipv4_header_classifier eihc_checker u_eihc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_frame_end, .out_valid, .out_stall,
  .out_status, .out_direction, .out_header_length
);
